// ===== design/rpa_pkg.sv =====
// Shared types and codes for the reference-counted page allocator.
// Request and response word layouts, operation and status codes, FSM states.
// No dependencies.
`default_nettype none

package rpa_pkg;

	localparam int OP_W    = 3;
	localparam int ADDR_W  = 32;
	localparam int STAT_W  = 3;
	localparam int PADDR_W = 24;
	localparam int CNT_W   = 8;
	localparam int CFG_W   = 12;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 3'd0,
		OP_FREE  = 3'd1,
		OP_INC   = 3'd2,
		OP_DEC   = 3'd3,
		OP_READ  = 3'd4
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 3'd0,
		STAT_NOMEM   = 3'd1,
		STAT_BADADDR = 3'd2,
		STAT_UNDER   = 3'd3,
		STAT_OVER    = 3'd4
	} status_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [ADDR_W-1:0] phys_addr;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [PADDR_W-1:0] page_addr;
		logic [CNT_W-1:0]   ref_count;
		logic               page_freed;
	} rsp_t;

	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE  = 3'b010,
		S_EXEC  = 3'b100
	} state_t;

endpackage

`default_nettype wire

// ===== design/rpa_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one read port, registered read.
// Used for the per-page count table and the free-list link table. No dependencies.
`default_nettype none

module rpa_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/refcounted_page_allocator_core.sv =====
// Top level of the reference-counted page allocator.
// Depends on rpa_pkg (types, codes) and rpa_ram (count and link tables).
`default_nettype none

// Page allocator with a LIFO free list and an 8-bit reference count per page.
// Each request word carries an operation (allocate, free, increment, decrement,
// read count) and a physical page address; every request returns exactly one
// response word. In the accept cycle (S_IDLE) the count table and the link
// table are read into their registered outputs, and in S_EXEC the count, the
// link and the list head are updated and the response is loaded into the
// output register. The next request is accepted only once that update is
// done, since it may depend on the new list head, so a request is not taken
// while the previous one is still in S_EXEC.
// A full response register that is not taken holds the update cycle.
// After reset all NUM_PAGES count entries are cleared one per cycle, during
// which req_ready stays low; first_usable_page writes are taken at any time.
// The free list starts empty: software fills it with free requests, and a
// page pushed onto an empty list links to itself to mark the list end.
module refcounted_page_allocator_core #(
	parameter int PAGE_SHIFT = 12,
	parameter int NUM_PAGES  = 4096
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// request channel
	input  wire logic                      req_valid,
	output logic                           req_ready,
	input  wire rpa_pkg::req_t             req,
	// response channel
	output logic                           rsp_valid,
	input  wire logic                      rsp_ready,
	output rpa_pkg::rsp_t                  rsp,
	// first_usable_page register
	input  wire logic                      cfg_we,
	input  wire logic [rpa_pkg::CFG_W-1:0] cfg_wdata
);

	localparam int PG_W = $clog2(NUM_PAGES);
	localparam int PN_W = rpa_pkg::ADDR_W - PAGE_SHIFT;
	localparam int CW   = rpa_pkg::CNT_W;

	// ---------------------------------------------------------------- state
	rpa_pkg::state_t state_q;
	logic [PG_W-1:0] clr_q;
	logic [rpa_pkg::CFG_W-1:0] fup_q;
	logic [PG_W-1:0] head_q;
	logic            empty_q;

	// request decoded at accept
	logic [rpa_pkg::OP_W-1:0] op_s1;
	logic [PG_W-1:0]          pg_s1;
	logic                     bad_s1;

	rpa_pkg::rsp_t rsp_q;
	logic          rsp_valid_q;

	// ---------------------------------------------------------------- decode
	logic            accept;
	logic [PN_W-1:0] pnum;
	logic            bad_op;
	logic            bad_addr;
	logic [PG_W-1:0] req_pg;

	assign req_ready = (state_q == rpa_pkg::S_IDLE);
	assign accept    = req_valid && req_ready;

	assign pnum   = req.phys_addr[rpa_pkg::ADDR_W-1:PAGE_SHIFT];
	assign req_pg = req.phys_addr[PAGE_SHIFT +: PG_W];

	always_comb begin
		unique case (req.op)
			rpa_pkg::OP_ALLOC,
			rpa_pkg::OP_FREE,
			rpa_pkg::OP_INC,
			rpa_pkg::OP_DEC,
			rpa_pkg::OP_READ: bad_op = 1'b0;
			default:          bad_op = 1'b1;
		endcase
	end

	// misaligned, below the managed range, or past the last page
	assign bad_addr = (|req.phys_addr[PAGE_SHIFT-1:0])
		|| ({1'b0, pnum} < (PN_W+1)'(fup_q))
		|| ({1'b0, pnum} >= (PN_W+1)'(NUM_PAGES));

	// ---------------------------------------------------------------- tables
	logic            cnt_we;
	logic [PG_W-1:0] cnt_waddr;
	logic [CW-1:0]   cnt_wdata;
	logic [CW-1:0]   cnt_rd;
	logic            link_we;
	logic [PG_W-1:0] link_waddr;
	logic [PG_W-1:0] link_wdata;
	logic [PG_W-1:0] link_rd;

	rpa_ram #(
		.DEPTH (NUM_PAGES),
		.WIDTH (CW)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (accept),
		.raddr (req_pg),
		.rdata (cnt_rd)
	);

	// allocate needs the successor of the current head
	rpa_ram #(
		.DEPTH (NUM_PAGES),
		.WIDTH (PG_W)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (accept),
		.raddr (head_q),
		.rdata (link_rd)
	);

	// ---------------------------------------------------------------- update
	logic            exec_go;
	logic            upd_cnt_we;
	logic [PG_W-1:0] upd_cnt_addr;
	logic [CW-1:0]   upd_cnt_data;
	logic            push;
	logic            pop_last;
	logic            pop;
	logic [31:0]     head_addr;
	rpa_pkg::rsp_t   res;

	// update cycle may retire only if the response register is free or draining
	assign exec_go   = (state_q == rpa_pkg::S_EXEC) && (!rsp_valid_q || rsp_ready);
	assign head_addr = 32'(head_q) << PAGE_SHIFT;
	assign pop_last  = (link_rd == head_q);

	always_comb begin
		res          = '0;
		res.status   = rpa_pkg::STAT_OK;
		upd_cnt_we   = 1'b0;
		upd_cnt_addr = pg_s1;
		upd_cnt_data = cnt_rd;
		push         = 1'b0;
		pop          = 1'b0;
		if (bad_s1) begin
			res.status = rpa_pkg::STAT_BADADDR;
		end else begin
			unique case (op_s1)
				rpa_pkg::OP_ALLOC: begin
					if (empty_q) begin
						res.status = rpa_pkg::STAT_NOMEM;
					end else begin
						pop           = 1'b1;
						upd_cnt_we    = 1'b1;
						upd_cnt_addr  = head_q;
						upd_cnt_data  = CW'(1);
						res.page_addr = head_addr[rpa_pkg::PADDR_W-1:0];
						res.ref_count = CW'(1);
					end
				end
				rpa_pkg::OP_FREE: begin
					upd_cnt_we = 1'b1;
					if (cnt_rd > CW'(1)) begin
						upd_cnt_data  = cnt_rd - CW'(1);
						res.ref_count = cnt_rd - CW'(1);
					end else begin
						upd_cnt_data   = '0;
						push           = 1'b1;
						res.page_freed = 1'b1;
					end
				end
				rpa_pkg::OP_INC: begin
					if (cnt_rd == rpa_pkg::CNT_MAX) begin
						res.status    = rpa_pkg::STAT_OVER;
						res.ref_count = rpa_pkg::CNT_MAX;
					end else begin
						upd_cnt_we    = 1'b1;
						upd_cnt_data  = cnt_rd + CW'(1);
						res.ref_count = cnt_rd + CW'(1);
					end
				end
				rpa_pkg::OP_DEC: begin
					if (cnt_rd == '0) begin
						res.status = rpa_pkg::STAT_UNDER;
					end else if (cnt_rd == CW'(1)) begin
						upd_cnt_we     = 1'b1;
						upd_cnt_data   = '0;
						push           = 1'b1;
						res.page_freed = 1'b1;
					end else begin
						upd_cnt_we    = 1'b1;
						upd_cnt_data  = cnt_rd - CW'(1);
						res.ref_count = cnt_rd - CW'(1);
					end
				end
				rpa_pkg::OP_READ: begin
					res.ref_count = cnt_rd;
				end
				default: begin
					res.status = rpa_pkg::STAT_BADADDR;
				end
			endcase
		end
	end

	// count table: clearing sweep after reset, else the update cycle
	always_comb begin
		if (state_q == rpa_pkg::S_CLEAR) begin
			cnt_we    = 1'b1;
			cnt_waddr = clr_q;
			cnt_wdata = '0;
		end else begin
			cnt_we    = exec_go && upd_cnt_we;
			cnt_waddr = upd_cnt_addr;
			cnt_wdata = upd_cnt_data;
		end
	end

	// push: new head links to the old head, or to itself at list end
	assign link_we    = exec_go && push;
	assign link_waddr = pg_s1;
	assign link_wdata = empty_q ? pg_s1 : head_q;

	// ---------------------------------------------------------------- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rpa_pkg::S_CLEAR;
			clr_q       <= '0;
			fup_q       <= '0;
			head_q      <= '0;
			empty_q     <= 1'b1;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				fup_q <= cfg_wdata;
			end
			// a new response loads only into a free or draining register
			if (exec_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				rpa_pkg::S_CLEAR: begin
					clr_q <= clr_q + PG_W'(1);
					if (clr_q == PG_W'(NUM_PAGES - 1)) begin
						state_q <= rpa_pkg::S_IDLE;
					end
				end
				rpa_pkg::S_IDLE: begin
					if (accept) begin
						state_q <= rpa_pkg::S_EXEC;
					end
				end
				rpa_pkg::S_EXEC: begin
					if (exec_go) begin
						state_q <= rpa_pkg::S_IDLE;
						if (push) begin
							head_q  <= pg_s1;
							empty_q <= 1'b0;
						end else if (pop) begin
							if (pop_last) begin
								empty_q <= 1'b1;
							end else begin
								head_q <= link_rd;
							end
						end
					end
				end
				default: begin
					state_q <= rpa_pkg::S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= req.op;
			pg_s1  <= req_pg;
			// allocate ignores the address
			bad_s1 <= bad_op || ((req.op != rpa_pkg::OP_ALLOC) && bad_addr);
		end
		if (exec_go) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ===== bench/page_alloc_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the page allocator: mirrors counts, links and the list head,
// predicts one response word per accepted request and compares them in order.
// Depends on rpa_pkg.
module page_alloc_checker #(
	parameter int PAGE_SHIFT = 12,
	parameter int NUM_PAGES  = 4096
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      req_valid,
	input  wire logic                      req_ready,
	input  wire rpa_pkg::req_t             req,
	input  wire logic                      rsp_valid,
	input  wire logic                      rsp_ready,
	input  wire rpa_pkg::rsp_t             rsp,
	input  wire logic                      cfg_we,
	input  wire logic [rpa_pkg::CFG_W-1:0] cfg_wdata,
	output int unsigned                    mismatches,
	output int unsigned                    outstanding
);

	localparam int PG_W = $clog2(NUM_PAGES);
	localparam int CW   = rpa_pkg::CNT_W;

	logic [CW-1:0]             ref_cnt [NUM_PAGES];
	logic [PG_W-1:0]           next_pg [NUM_PAGES];
	logic [PG_W-1:0]           head_pg;
	logic                      list_empty;
	logic [rpa_pkg::CFG_W-1:0] first_page;
	rpa_pkg::rsp_t             pending_rsps [$];

	function automatic void push_free(input logic [PG_W-1:0] pg);
		// a page pushed onto an empty list links to itself
		next_pg[pg] = list_empty ? pg : head_pg;
		head_pg = pg;
		list_empty = 1'b0;
	endfunction

	function automatic rpa_pkg::rsp_t serve_request(input rpa_pkg::req_t r);
		rpa_pkg::rsp_t res;
		logic [rpa_pkg::ADDR_W-1:0] pnum;
		logic [PG_W-1:0] pg;
		logic [CW-1:0] cnt;
		res = '0;
		res.status = rpa_pkg::STAT_OK;
		pnum = r.phys_addr >> PAGE_SHIFT;
		if (r.op == rpa_pkg::OP_ALLOC) begin
			if (list_empty) begin
				res.status = rpa_pkg::STAT_NOMEM;
			end else begin
				pg = head_pg;
				if (next_pg[pg] == pg)
					list_empty = 1'b1;
				else
					head_pg = next_pg[pg];
				ref_cnt[pg] = CW'(1);
				res.page_addr = rpa_pkg::PADDR_W'(32'(pg) << PAGE_SHIFT);
				res.ref_count = CW'(1);
			end
			return res;
		end
		if (r.op > rpa_pkg::OP_READ || (r.phys_addr & ((32'd1 << PAGE_SHIFT) - 1)) != 0
				|| pnum < first_page || pnum >= NUM_PAGES) begin
			res.status = rpa_pkg::STAT_BADADDR;
			return res;
		end
		pg = pnum[PG_W-1:0];
		cnt = ref_cnt[pg];
		case (rpa_pkg::op_t'(r.op))
		rpa_pkg::OP_FREE: begin
			if (cnt > 1) begin
				ref_cnt[pg] = cnt - CW'(1);
				res.ref_count = cnt - CW'(1);
			end else begin
				ref_cnt[pg] = '0;
				push_free(pg);
				res.page_freed = 1'b1;
			end
		end
		rpa_pkg::OP_INC: begin
			if (cnt == rpa_pkg::CNT_MAX) begin
				res.status = rpa_pkg::STAT_OVER;
				res.ref_count = rpa_pkg::CNT_MAX;
			end else begin
				ref_cnt[pg] = cnt + CW'(1);
				res.ref_count = cnt + CW'(1);
			end
		end
		rpa_pkg::OP_DEC: begin
			if (cnt == 0) begin
				res.status = rpa_pkg::STAT_UNDER;
			end else if (cnt == 1) begin
				ref_cnt[pg] = '0;
				push_free(pg);
				res.page_freed = 1'b1;
			end else begin
				ref_cnt[pg] = cnt - CW'(1);
				res.ref_count = cnt - CW'(1);
			end
		end
		default: res.ref_count = cnt;
		endcase
		return res;
	endfunction

	function automatic int unsigned field_diff(input string name,
			input longint unsigned want, input longint unsigned got);
		if (want == got)
			return 0;
		$error("%s: expected %0d, got %0d", name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rpa_pkg::rsp_t want;
		int unsigned bad;
		if (!arst_n) begin
			for (int i = 0; i < NUM_PAGES; i++) begin
				ref_cnt[i] = '0;
				next_pg[i] = '0;
			end
			head_pg = '0;
			list_empty = 1'b1;
			first_page = '0;
			pending_rsps.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			bad = 0;
			// response first: it can never belong to a request taken at this edge
			if (rsp_valid && rsp_ready) begin
				if (pending_rsps.size() == 0) begin
					$error("response word with nothing expected: %p", rsp);
					bad++;
				end else begin
					want = pending_rsps.pop_front();
					bad += field_diff("status", want.status, rsp.status);
					bad += field_diff("page_addr", want.page_addr, rsp.page_addr);
					bad += field_diff("ref_count", want.ref_count, rsp.ref_count);
					bad += field_diff("page_freed", want.page_freed, rsp.page_freed);
				end
			end
			// a request taken at this edge still sees the old floor
			if (req_valid && req_ready)
				pending_rsps.push_back(serve_request(req));
			if (cfg_we)
				first_page = cfg_wdata;
			mismatches <= mismatches + bad;
			outstanding <= pending_rsps.size();
		end
	end

endmodule

// ===== bench/refcounted_page_allocator_core_tb.sv =====
`timescale 1ns / 1ps
// Top of the page allocator bench: clock, reset, request words, response stalls
// and the verdict. Depends on rpa_pkg, the allocator RTL and page_alloc_checker.
module refcounted_page_allocator_core_tb;

	localparam int PAGE_SHIFT = 12;
	localparam int NUM_PAGES  = 4096;
	localparam int OP_W       = rpa_pkg::OP_W;
	localparam int ADDR_W     = rpa_pkg::ADDR_W;
	localparam int CFG_W      = rpa_pkg::CFG_W;
	// op codes the block does not define; they must come back as bad address
	localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd5;
	localparam logic [OP_W-1:0] OP_UNDEF_MID = 3'd6;
	localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;
	// random traffic stays on a small window of pages so counts and the list
	// actually interact
	localparam int POOL_PAGES = 24;
	// a request passes S_EXEC and the output register; this is ample
	localparam int SETTLE_CYCLES = 16;
	// clearing pass plus ~500 words with their idle bursts and response stalls,
	// taken many times over
	localparam int unsigned CYCLE_LIMIT = 300_000;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_ready;
	rpa_pkg::req_t    req = '0;
	logic             rsp_valid;
	logic             rsp_ready = 1'b0;
	rpa_pkg::rsp_t    rsp;
	logic             cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned idle_pct = 0;   // chance of an idle burst, both sides; 0 = none
	int unsigned stall_left = 0;
	int unsigned cycles = 0;

	refcounted_page_allocator_core #(
		.PAGE_SHIFT(PAGE_SHIFT),
		.NUM_PAGES (NUM_PAGES)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	page_alloc_checker #(
		.PAGE_SHIFT(PAGE_SHIFT),
		.NUM_PAGES (NUM_PAGES)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// response side: ready drops for bursts of random length
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp_ready <= 1'b0;
		end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2) begin
			stall_left <= $urandom_range(0, 6);
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	function automatic logic [ADDR_W-1:0] page_base(input int unsigned pg);
		return ADDR_W'(pg) << PAGE_SHIFT;
	endfunction

	// Present one request word and hold it until taken. Valid is only lowered
	// when an idle burst goes in front, so back-to-back words never see valid
	// dropped and raised in the same step.
	task automatic send_word(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= '{op: op, phys_addr: addr};
		do @(posedge clk); while (!req_ready);
	endtask

	// Stop sending and wait for every outstanding response word, then let the
	// pipeline settle. Register writes follow this, except the first one after reset.
	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_first_page(input logic [CFG_W-1:0] pg);
		cfg_we <= 1'b1;
		cfg_wdata <= pg;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly well-formed requests on a window starting at the first usable
	// page; some pure noise, some near misses (misaligned, below the window,
	// beyond the table).
	task automatic random_word(input int unsigned first_pg);
		int unsigned roll;
		int unsigned span;
		logic [OP_W-1:0] op;
		logic [ADDR_W-1:0] addr;
		span = (NUM_PAGES - first_pg < POOL_PAGES) ? NUM_PAGES - first_pg : POOL_PAGES;
		addr = page_base(first_pg + $urandom_range(0, span - 1));
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			op = OP_W'($urandom);
			addr = $urandom;
		end else if (roll < 15) begin
			op = OP_W'($urandom_range(rpa_pkg::OP_FREE, rpa_pkg::OP_READ));
			case ($urandom_range(0, 2))
			0: addr = addr | $urandom_range(1, (1 << PAGE_SHIFT) - 1);
			1: addr = (first_pg > 0) ? page_base($urandom_range(0, first_pg - 1))
				: page_base($urandom_range(NUM_PAGES, (1 << (ADDR_W - PAGE_SHIFT)) - 1));
			default: addr = page_base($urandom_range(NUM_PAGES,
				(1 << (ADDR_W - PAGE_SHIFT)) - 1));
			endcase
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 26)
				op = rpa_pkg::OP_ALLOC;
			else if (roll < 46)
				op = rpa_pkg::OP_FREE;
			else if (roll < 66)
				op = rpa_pkg::OP_INC;
			else if (roll < 86)
				op = rpa_pkg::OP_DEC;
			else
				op = rpa_pkg::OP_READ;
		end
		send_word(op, addr);
	endtask

	initial begin
		int unsigned hot_pg;
		int unsigned first_pg;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed, every page usable ----
		// req_ready stays low through the clearing pass; send_word just waits
		set_first_page('0);
		idle_pct = 20;
		send_word(rpa_pkg::OP_ALLOC, '0);                    // empty list: out of pages
		send_word(rpa_pkg::OP_FREE, page_base(0));           // build list: free at count 0
		send_word(rpa_pkg::OP_FREE, page_base(NUM_PAGES - 1));
		send_word(rpa_pkg::OP_FREE, page_base(1));
		send_word(rpa_pkg::OP_FREE, page_base(1) | 1);       // misaligned
		send_word(rpa_pkg::OP_INC, page_base(NUM_PAGES));    // one past the table
		send_word(rpa_pkg::OP_READ, '1);                     // all ones address
		send_word(OP_UNDEF_LO, page_base(2));                // undefined ops
		send_word(OP_UNDEF_MID, page_base(2));
		send_word(OP_UNDEF_HI, page_base(3));
		send_word(rpa_pkg::OP_ALLOC, '1);                    // pops page 1
		send_word(rpa_pkg::OP_INC, page_base(1));            // 1 -> 2
		send_word(rpa_pkg::OP_READ, page_base(1));
		send_word(rpa_pkg::OP_FREE, page_base(1));           // free above one only decrements
		send_word(rpa_pkg::OP_DEC, page_base(1));            // decrement at one frees
		send_word(rpa_pkg::OP_DEC, page_base(1));            // decrement at zero: underflow
		send_word(rpa_pkg::OP_FREE, page_base(1));           // page already listed: pushed again
		send_word(rpa_pkg::OP_ALLOC, '0);
		send_word(rpa_pkg::OP_ALLOC, '0);
		send_word(rpa_pkg::OP_INC, page_base(NUM_PAGES - 1));
		send_word(rpa_pkg::OP_DEC, page_base(NUM_PAGES - 1));
		send_word(rpa_pkg::OP_READ, page_base(0));
		send_word(rpa_pkg::OP_ALLOC, '0);
		// sender holds off until every response is back
		drain();

		// drive one page to saturation and past it
		hot_pg = $urandom_range(POOL_PAGES, NUM_PAGES - 1);
		repeat (rpa_pkg::CNT_MAX + 2) send_word(rpa_pkg::OP_INC, page_base(hot_pg));
		send_word(rpa_pkg::OP_READ, page_base(hot_pg));
		send_word(rpa_pkg::OP_FREE, page_base(hot_pg));
		repeat (60) random_word(0);
		drain();

		// ---- only the top page is usable ----
		set_first_page('1);
		idle_pct = 35;
		repeat (30) random_word(NUM_PAGES - 1);
		drain();

		// ---- random floor ----
		first_pg = $urandom_range(1, NUM_PAGES - 2);
		set_first_page(CFG_W'(first_pg));
		idle_pct = 10;
		repeat (60) random_word(first_pg);
		drain();

		// ---- low floor, heavy idling ----
		first_pg = $urandom_range(1, 15);
		set_first_page(CFG_W'(first_pg));
		idle_pct = 40;
		repeat (40) random_word(first_pg);
		drain();

		// ---- back to zero, full rate on both sides to the end ----
		set_first_page('0);
		idle_pct = 0;
		repeat (30) random_word(0);
		drain();

		if (mismatches == 0 && outstanding == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
